// ----- src/sws_pkg.sv -----
// shared types, codes and constants of the sliding window sender
package sws_pkg;

  localparam int SEQ_BITS  = 3;
  localparam int SEQ_SPACE = 1 << SEQ_BITS;
  localparam int PAY_BITS  = 32;
  localparam int WS_BITS   = 3;
  localparam int ACK_BITS  = 3;

  localparam logic [WS_BITS-1:0] WS_RESET = WS_BITS'(4);
  localparam logic [1:0]         FULL_DUP = 2'd3;

  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_NEW     = 2'd1;
  localparam logic [1:0] KIND_FAST    = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  typedef struct packed {
    logic load;
    logic cfg_we;
  } cmd_t;

endpackage

// ----- src/sws_ram.sv -----
// generic simple dual port ram with registered read
module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/sws_ctrl.sv -----
// controller: input/output and config handshakes and result slot state
module sws_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  output sws_pkg::cmd_t cmd
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic take;

  assign in_stall  = (state_r == ST_FULL) && out_stall;
  assign out_valid = (state_r == ST_FULL);
  assign cfg_ready = (state_r == ST_EMPTY);
  assign take      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (in_valid) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (!out_stall && !in_valid) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_comb begin
    cmd.load   = take;
    cmd.cfg_we = cfg_valid && cfg_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/sws_dp.sv -----
// datapath: window state, packet store and result word registers
module sws_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sws_pkg::cmd_t                   cmd,
  input  logic [sws_pkg::WS_BITS-1:0]     cfg_window_size,
  input  logic [1:0]                      in_op,
  input  logic [sws_pkg::PAY_BITS-1:0]    in_payload,
  input  logic [sws_pkg::ACK_BITS-1:0]    in_ack_number,
  input  logic                            in_checksum_ok,
  output logic                            out_accepted,
  output logic [1:0]                      out_tx_kind,
  output logic [sws_pkg::SEQ_BITS-1:0]    out_tx_seq,
  output logic [sws_pkg::PAY_BITS-1:0]    out_tx_payload,
  output logic [1:0]                      out_timer_action,
  output logic [sws_pkg::SEQ_BITS-1:0]    out_window_base,
  output logic [sws_pkg::SEQ_BITS-1:0]    out_next_seq
);

  logic [sws_pkg::WS_BITS-1:0]  ws_r;
  logic [sws_pkg::SEQ_BITS-1:0] base_r, base_nxt;
  logic [sws_pkg::SEQ_BITS-1:0] send_r, send_nxt;
  logic [sws_pkg::ACK_BITS-1:0] last_ack_r, last_ack_nxt;
  logic [1:0]                   dup_r, dup_nxt, dup_inc;
  logic                         acc_r, acc_nxt;
  logic [1:0]                   kind_r, kind_nxt;
  logic [sws_pkg::SEQ_BITS-1:0] seq_r, seq_nxt;
  logic [1:0]                   timer_r, timer_nxt;
  logic [sws_pkg::PAY_BITS-1:0] pay_r, pay_nxt;
  logic                         use_ram_r, use_ram_nxt;

  logic [sws_pkg::SEQ_BITS+sws_pkg::WS_BITS-1:0] win_sum;
  logic [sws_pkg::SEQ_BITS-1:0] win_end;
  logic [sws_pkg::SEQ_BITS-1:0] ack_seq;
  logic [sws_pkg::SEQ_BITS-1:0] prev;
  logic                         full;
  logic                         in_win;
  logic                         ram_we;
  logic                         ram_re;
  logic [sws_pkg::PAY_BITS-1:0] ram_rdata;

  assign win_sum = {{sws_pkg::WS_BITS{1'b0}}, base_r} + {{sws_pkg::SEQ_BITS{1'b0}}, ws_r};
  assign win_end = win_sum[sws_pkg::SEQ_BITS-1:0];
  assign full    = (win_end == send_r);
  assign ack_seq = sws_pkg::SEQ_BITS'(in_ack_number);
  assign prev    = sws_pkg::SEQ_BITS'(ack_seq - sws_pkg::SEQ_BITS'(1));
  assign dup_inc = dup_r + 2'd1;

  always_comb begin
    if (base_r < win_end) begin
      in_win = (prev >= base_r) && (prev < win_end);
    end else begin
      in_win = (prev >= base_r) || (prev < win_end);
    end
  end

  always_comb begin
    base_nxt     = base_r;
    send_nxt     = send_r;
    last_ack_nxt = last_ack_r;
    dup_nxt      = dup_r;
    acc_nxt      = 1'b0;
    kind_nxt     = sws_pkg::KIND_NONE;
    seq_nxt      = '0;
    timer_nxt    = sws_pkg::TMR_NONE;
    pay_nxt      = '0;
    use_ram_nxt  = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    unique case (in_op)
      sws_pkg::OP_SEND: begin
        if (!full) begin
          acc_nxt   = 1'b1;
          ram_we    = cmd.load;
          kind_nxt  = sws_pkg::KIND_NEW;
          seq_nxt   = send_r;
          pay_nxt   = in_payload;
          send_nxt  = sws_pkg::SEQ_BITS'(send_r + sws_pkg::SEQ_BITS'(1));
          if (base_r == send_r) timer_nxt = sws_pkg::TMR_START;
        end
      end
      sws_pkg::OP_ACK: begin
        if (in_checksum_ok) begin
          acc_nxt = 1'b1;
          if (in_ack_number == last_ack_r) begin
            dup_nxt = dup_inc;
            if (dup_inc == sws_pkg::FULL_DUP) begin
              dup_nxt     = 2'd0;
              kind_nxt    = sws_pkg::KIND_FAST;
              seq_nxt     = base_r;
              use_ram_nxt = 1'b1;
              ram_re      = cmd.load;
            end
          end else begin
            last_ack_nxt = in_ack_number;
            dup_nxt      = 2'd0;
          end
          if (in_win) begin
            base_nxt = ack_seq;
            if (ack_seq == send_r) timer_nxt = sws_pkg::TMR_STOP;
          end
        end
      end
      sws_pkg::OP_TIMEOUT: begin
        acc_nxt     = 1'b1;
        dup_nxt     = 2'd0;
        timer_nxt   = sws_pkg::TMR_RESTART;
        kind_nxt    = sws_pkg::KIND_TIMEOUT;
        seq_nxt     = base_r;
        use_ram_nxt = 1'b1;
        ram_re      = cmd.load;
      end
      default: begin
      end
    endcase
  end

  sws_ram #(
    .WIDTH (sws_pkg::PAY_BITS),
    .DEPTH (sws_pkg::SEQ_SPACE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (send_r),
    .wdata (in_payload),
    .re    (ram_re),
    .raddr (base_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r       <= sws_pkg::WS_RESET;
      base_r     <= '0;
      send_r     <= '0;
      last_ack_r <= '0;
      dup_r      <= 2'd0;
      acc_r      <= 1'b0;
      kind_r     <= sws_pkg::KIND_NONE;
      seq_r      <= '0;
      timer_r    <= sws_pkg::TMR_NONE;
      use_ram_r  <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        ws_r <= cfg_window_size;
      end
      if (cmd.load) begin
        base_r     <= base_nxt;
        send_r     <= send_nxt;
        last_ack_r <= last_ack_nxt;
        dup_r      <= dup_nxt;
        acc_r      <= acc_nxt;
        kind_r     <= kind_nxt;
        seq_r      <= seq_nxt;
        timer_r    <= timer_nxt;
        use_ram_r  <= use_ram_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pay_r <= pay_nxt;
    end
  end

  assign out_accepted     = acc_r;
  assign out_tx_kind      = kind_r;
  assign out_tx_seq       = seq_r;
  assign out_tx_payload   = use_ram_r ? ram_rdata : pay_r;
  assign out_timer_action = timer_r;
  assign out_window_base  = base_r;
  assign out_next_seq     = send_r;

endmodule

// ----- src/sliding_window_sender_top.sv -----
// top level of the sliding window sender
//
// usage:
// - input channel (in_valid / in_stall) takes one event word: a send with
//   in_payload, an ack with in_ack_number and in_checksum_ok, or a timer expiry
// - every event gives exactly one result word on the output channel
//   (out_valid / out_stall): what was transmitted, the timer command and the
//   window base and next sequence number after the event
// - a result is registered and shows in the cycle after its word is accepted;
//   the packet store read for a retransmit is registered with it
// - throughput is one event per cycle while the receiver keeps out_stall low;
//   the one result register is refilled in the cycle it is taken
// - when the receiver stalls, the result holds and in_stall rises while a
//   result is pending
// - cfg_window_size is written through cfg_valid / cfg_ready; cfg_ready is
//   high while no result is pending
// - synchronous reset clears the window to empty, sequence numbers and the
//   duplicate ack count to zero and the window size to 4; the packet store
//   is not cleared and a slot reads valid only after a send wrote it
module sliding_window_sender_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_op,
  input  logic [sws_pkg::PAY_BITS-1:0] in_payload,
  input  logic [sws_pkg::ACK_BITS-1:0] in_ack_number,
  input  logic                         in_checksum_ok,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_accepted,
  output logic [1:0]                   out_tx_kind,
  output logic [sws_pkg::SEQ_BITS-1:0] out_tx_seq,
  output logic [sws_pkg::PAY_BITS-1:0] out_tx_payload,
  output logic [1:0]                   out_timer_action,
  output logic [sws_pkg::SEQ_BITS-1:0] out_window_base,
  output logic [sws_pkg::SEQ_BITS-1:0] out_next_seq,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sws_pkg::WS_BITS-1:0]  cfg_window_size
);

  sws_pkg::cmd_t cmd;

  sws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  sws_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_window_size  (cfg_window_size),
    .in_op            (in_op),
    .in_payload       (in_payload),
    .in_ack_number    (in_ack_number),
    .in_checksum_ok   (in_checksum_ok),
    .out_accepted     (out_accepted),
    .out_tx_kind      (out_tx_kind),
    .out_tx_seq       (out_tx_seq),
    .out_tx_payload   (out_tx_payload),
    .out_timer_action (out_timer_action),
    .out_window_base  (out_window_base),
    .out_next_seq     (out_next_seq)
  );

  // an accepted word always leaves a result behind
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word produced no result");

  // input stalls only behind a pending result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // nothing sent means zero sequence and payload
  a_idle_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tx_kind == sws_pkg::KIND_NONE) |->
      (out_tx_seq == '0 && out_tx_payload == '0))
    else $error("nonzero tx fields with nothing sent");

  // a new packet never stops or restarts the timer
  a_new_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tx_kind == sws_pkg::KIND_NEW) |->
      (out_timer_action == sws_pkg::TMR_NONE || out_timer_action == sws_pkg::TMR_START))
    else $error("bad timer action on new packet");

  // a refused or corrupt word changes nothing and sends nothing
  a_refused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |->
      (out_tx_kind == sws_pkg::KIND_NONE && out_timer_action == sws_pkg::TMR_NONE))
    else $error("refused word sent a packet or touched the timer");

endmodule

// ----- sim/tb_top.sv -----
// testbench for the sliding window sender: scripted and random events, predicted results, checks
module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]                   op;
    logic [sws_pkg::PAY_BITS-1:0] payload;
    logic [sws_pkg::ACK_BITS-1:0] ack;
    logic                         checksum_ok;
  } sws_event_t;

  typedef struct packed {
    logic                         accepted;
    logic [1:0]                   kind;
    logic [sws_pkg::SEQ_BITS-1:0] seq;
    logic [sws_pkg::PAY_BITS-1:0] payload;
    logic [1:0]                   timer;
    logic [sws_pkg::SEQ_BITS-1:0] base;
    logic [sws_pkg::SEQ_BITS-1:0] next;
  } tx_report_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   in_op = sws_pkg::OP_SEND;
  logic [sws_pkg::PAY_BITS-1:0] in_payload = '0;
  logic [sws_pkg::ACK_BITS-1:0] in_ack_number = '0;
  logic                         in_checksum_ok = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_accepted;
  logic [1:0]                   out_tx_kind;
  logic [sws_pkg::SEQ_BITS-1:0] out_tx_seq;
  logic [sws_pkg::PAY_BITS-1:0] out_tx_payload;
  logic [1:0]                   out_timer_action;
  logic [sws_pkg::SEQ_BITS-1:0] out_window_base;
  logic [sws_pkg::SEQ_BITS-1:0] out_next_seq;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [sws_pkg::WS_BITS-1:0]  cfg_window_size = sws_pkg::WS_RESET;

  sliding_window_sender_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_payload       (in_payload),
    .in_ack_number    (in_ack_number),
    .in_checksum_ok   (in_checksum_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_tx_kind      (out_tx_kind),
    .out_tx_seq       (out_tx_seq),
    .out_tx_payload   (out_tx_payload),
    .out_timer_action (out_timer_action),
    .out_window_base  (out_window_base),
    .out_next_seq     (out_next_seq),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_size  (cfg_window_size)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // mirror of the sender state
  logic [sws_pkg::WS_BITS-1:0]  win_size = sws_pkg::WS_RESET;
  logic [sws_pkg::SEQ_BITS-1:0] base_seq = '0;
  logic [sws_pkg::SEQ_BITS-1:0] send_seq = '0;
  logic [sws_pkg::SEQ_BITS-1:0] last_ack = '0;
  logic [1:0]                   dup_count = '0;
  logic [sws_pkg::PAY_BITS-1:0] sent_store [sws_pkg::SEQ_SPACE];
  bit                           slot_written [sws_pkg::SEQ_SPACE];

  sws_event_t pending_events [$];
  tx_report_t tx_expected [$];

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  bit calm_mode = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int dup_left = 0;
  int idle_cycles = 0;
  int errors = 0;
  int event_total = 0;
  int results_seen = 0;
  int settings_seen = 0;
  int fast_count = 0;
  int timeout_count = 0;
  int refused_count = 0;
  int stop_count = 0;

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (calm_mode || r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic bit ack_in_window(logic [sws_pkg::SEQ_BITS-1:0] s);
    logic [sws_pkg::SEQ_BITS-1:0] lim;
    lim = base_seq + win_size;
    if (base_seq < lim) return s >= base_seq && s < lim;
    return s >= base_seq || s < lim;
  endfunction

  // a retransmit of the base slot must never hit a slot no send has filled
  function automatic bit reads_blank_slot(sws_event_t e);
    if (e.op == sws_pkg::OP_TIMEOUT) return !slot_written[base_seq];
    if (e.op == sws_pkg::OP_ACK && e.checksum_ok && e.ack == last_ack &&
        dup_count + 2'd1 == sws_pkg::FULL_DUP)
      return !slot_written[base_seq];
    return 1'b0;
  endfunction

  function automatic tx_report_t advance_window(sws_event_t e);
    tx_report_t r;
    logic [sws_pkg::SEQ_BITS-1:0] lim;
    logic [sws_pkg::SEQ_BITS-1:0] prev;
    r = '0;
    case (e.op)
      sws_pkg::OP_SEND: begin
        lim = base_seq + win_size;
        if (lim != send_seq) begin
          r.accepted = 1'b1;
          sent_store[send_seq] = e.payload;
          slot_written[send_seq] = 1'b1;
          if (base_seq == send_seq) r.timer = sws_pkg::TMR_START;
          r.kind = sws_pkg::KIND_NEW;
          r.seq = send_seq;
          r.payload = e.payload;
          send_seq = send_seq + sws_pkg::SEQ_BITS'(1);
        end else begin
          refused_count++;
        end
      end
      sws_pkg::OP_ACK: begin
        if (e.checksum_ok) begin
          r.accepted = 1'b1;
          if (e.ack == last_ack) begin
            if (dup_count + 2'd1 == sws_pkg::FULL_DUP) begin
              dup_count = '0;
              r.kind = sws_pkg::KIND_FAST;
              r.seq = base_seq;
              r.payload = sent_store[base_seq];
              fast_count++;
            end else begin
              dup_count = dup_count + 2'd1;
            end
          end else begin
            last_ack = e.ack;
            dup_count = '0;
          end
          prev = e.ack - sws_pkg::ACK_BITS'(1);
          if (ack_in_window(prev)) begin
            base_seq = e.ack;
            if (base_seq == send_seq) begin
              r.timer = sws_pkg::TMR_STOP;
              stop_count++;
            end
          end
        end
      end
      sws_pkg::OP_TIMEOUT: begin
        r.accepted = 1'b1;
        dup_count = '0;
        r.timer = sws_pkg::TMR_RESTART;
        r.kind = sws_pkg::KIND_TIMEOUT;
        r.seq = base_seq;
        r.payload = sent_store[base_seq];
        timeout_count++;
      end
      default: begin
      end
    endcase
    r.base = base_seq;
    r.next = send_seq;
    return r;
  endfunction

  function automatic sws_event_t mk_event(logic [1:0] op,
                                          logic [sws_pkg::PAY_BITS-1:0] payload,
                                          logic [sws_pkg::ACK_BITS-1:0] ack,
                                          logic checksum_ok);
    sws_event_t e;
    e.op = op;
    e.payload = payload;
    e.ack = ack;
    e.checksum_ok = checksum_ok;
    return e;
  endfunction

  function automatic sws_event_t make_random();
    sws_event_t e;
    int pick;
    logic [sws_pkg::SEQ_BITS-1:0] flight;
    e.op = sws_pkg::OP_ACK;
    e.payload = $urandom;
    e.ack = sws_pkg::ACK_BITS'($urandom_range(0, 7));
    e.checksum_ok = 1'b1;
    pick = int'($urandom_range(0, 15));
    if (pick == 0) e.payload = '0;
    else if (pick == 1) e.payload = '1;
    flight = send_seq - base_seq;
    pick = int'($urandom_range(0, 99));
    if (dup_left > 0) begin
      dup_left--;
      e.ack = last_ack;
    end else if (pick < 35) begin
      e.op = sws_pkg::OP_SEND;
    end else if (pick < 62) begin
      e.ack = base_seq + sws_pkg::SEQ_BITS'($urandom_range(int'(flight), (flight != 0) ? 1 : 0));
    end else if (pick < 75) begin
      e.ack = last_ack;
      dup_left = 2;
    end else if (pick < 83) begin
      e.op = sws_pkg::OP_TIMEOUT;
    end else if (pick < 90) begin
      e.checksum_ok = 1'b0;
    end else if (pick >= 95) begin
      e.op = OP_UNUSED;
      e.checksum_ok = 1'($urandom_range(0, 1));
    end
    return e;
  endfunction

  task automatic push_event(input sws_event_t e);
    tx_expected.push_back(advance_window(e));
    pending_events.push_back(e);
    event_total++;
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || tx_expected.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  task automatic write_window(input logic [sws_pkg::WS_BITS-1:0] w);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_window_size <= w;
    do @(posedge clk); while (!cfg_ready);
    win_size = w;
    settings_seen++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [sws_pkg::WS_BITS-1:0] w, input int n, input bit calm);
    sws_event_t e;
    int made;
    write_window(w);
    calm_mode = calm;
    made = 0;
    while (made < n) begin
      e = make_random();
      if (reads_blank_slot(e)) e.op = sws_pkg::OP_SEND;
      push_event(e);
      if (e.op != OP_UNUSED && !(e.op == sws_pkg::OP_ACK && !e.checksum_ok)) made++;
    end
  endtask

  task automatic check_field(input string name, input logic [sws_pkg::PAY_BITS-1:0] want,
                             input logic [sws_pkg::PAY_BITS-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // input driver
  always @(negedge clk) begin : drive_in
    sws_event_t job;
    logic busy;
    if (in_valid && in_fire) in_gap = pick_gap();
    busy = in_valid && !in_fire;
    if (!busy && in_gap > 0) begin
      in_gap--;
    end else if (!busy && rst_n && pending_events.size() != 0) begin
      job = pending_events.pop_front();
      in_op <= job.op;
      in_payload <= job.payload;
      in_ack_number <= job.ack;
      in_checksum_ok <= job.checksum_ok;
      busy = 1'b1;
    end
    in_valid <= busy;
  end

  // result side back-pressure
  always @(negedge clk) begin : stall_out
    if (out_fire) out_gap = pick_gap();
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin : check_out
    tx_report_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    out_fire <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (tx_expected.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
      end else begin
        want = tx_expected.pop_front();
        check_field("accepted", sws_pkg::PAY_BITS'(want.accepted),
                    sws_pkg::PAY_BITS'(out_accepted));
        check_field("tx_kind", sws_pkg::PAY_BITS'(want.kind), sws_pkg::PAY_BITS'(out_tx_kind));
        check_field("tx_seq", sws_pkg::PAY_BITS'(want.seq), sws_pkg::PAY_BITS'(out_tx_seq));
        check_field("tx_payload", want.payload, out_tx_payload);
        check_field("timer_action", sws_pkg::PAY_BITS'(want.timer),
                    sws_pkg::PAY_BITS'(out_timer_action));
        check_field("window_base", sws_pkg::PAY_BITS'(want.base),
                    sws_pkg::PAY_BITS'(out_window_base));
        check_field("next_seq", sws_pkg::PAY_BITS'(want.next), sws_pkg::PAY_BITS'(out_next_seq));
      end
    end
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // scripted opening at the reset window of 4
    push_event(mk_event(OP_UNUSED, '1, 3'd7, 1'b1));
    push_event(mk_event(sws_pkg::OP_ACK, '0, 3'd0, 1'b1));  // ack 0 before any ack is a duplicate
    push_event(mk_event(sws_pkg::OP_ACK, '0, 3'd5, 1'b0));  // corrupt ack
    push_event(mk_event(sws_pkg::OP_SEND, 32'h0000_0000, 3'd0, 1'b0));
    push_event(mk_event(sws_pkg::OP_SEND, 32'hFFFF_FFFF, 3'd0, 1'b0));
    push_event(mk_event(sws_pkg::OP_SEND, 32'hA5A5_A5A5, 3'd0, 1'b0));
    push_event(mk_event(sws_pkg::OP_SEND, 32'h5A5A_5A5A, 3'd0, 1'b0));
    push_event(mk_event(sws_pkg::OP_SEND, 32'h1234_5678, 3'd0, 1'b0)); // window full
    push_event(mk_event(sws_pkg::OP_ACK, '0, 3'd0, 1'b1));
    push_event(mk_event(sws_pkg::OP_ACK, '0, 3'd0, 1'b1));  // third duplicate
    push_event(mk_event(sws_pkg::OP_TIMEOUT, '0, 3'd0, 1'b0));
    push_event(mk_event(sws_pkg::OP_ACK, '0, 3'd2, 1'b1));
    push_event(mk_event(sws_pkg::OP_ACK, '0, 3'd4, 1'b1));  // all acked, timer stop
    push_event(mk_event(sws_pkg::OP_SEND, 32'hDEAD_BEEF, 3'd0, 1'b1));
    push_event(mk_event(sws_pkg::OP_ACK, '0, 3'd0, 1'b1));  // ack 0 wraps, moves base past send
    push_event(mk_event(sws_pkg::OP_TIMEOUT, '1, 3'd7, 1'b1));
    push_event(mk_event(sws_pkg::OP_ACK, '1, 3'd7, 1'b1));
    push_event(mk_event(OP_UNUSED, '0, 3'd0, 1'b0));

    run_phase(3'd1, 40, 1'b0);
    run_phase(3'd7, 40, 1'b1);
    run_phase(3'd0, 40, 1'b0);
    run_phase(3'd3, 40, 1'b0);
    run_phase(3'd4, 40, 1'b1);
    run_phase(3'd2, 40, 1'b0);
    run_phase(3'd6, 40, 1'b0);
    run_phase(3'd5, 40, 1'b0);
    run_phase(3'd7, 40, 1'b0);
    run_phase(3'd1, 30, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("run covered %0d events, %0d result words, %0d window sizes",
             event_total, results_seen, settings_seen);
    $display("fast retransmits %0d, timeout retransmits %0d, refused sends %0d, timer stops %0d",
             fast_count, timeout_count, refused_count, stop_count);
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ----- files.f -----
src/sws_pkg.sv
src/sws_ram.sv
src/sws_ctrl.sv
src/sws_dp.sv
src/sliding_window_sender_top.sv
sim/tb_top.sv
